### rtl/sia_pkg.sv
// shared types and constants for the sorted insert array
`default_nettype none
package sia_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int POS_W       = 6;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IN_DATA_W   = ((VALUE_WIDTH + POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((VALUE_WIDTH + CNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                   ins_en;
    logic                   rem_en;
    logic [VALUE_WIDTH-1:0] item;
    logic [CNT_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/sorted_insert_array.sv
// top level of the sorted insert array: command decode, cell row and result register
//
// usage
//   a request on the in_ channel carries a command in in_tuser (insert, read,
//   remove) and the value and position in in_tdata. every request yields one
//   result on the out_ channel: the read value, a status in out_tuser and the
//   entry count after the command.
//   entries are kept in ascending unsigned order in a row of cells; an insert
//   places the value after all equal entries and every cell above moves up in
//   the same cycle, a remove moves every cell above the position down.
// latency and throughput
//   one request per cycle while no result is stalled; the result appears in the
//   output register on the cycle after acceptance. the figure is set by the cell
//   row, which shifts all cells at once, and the read select across the row.
// reset
//   rst_n (synchronous, active low) empties the store (count to zero) and
//   drops any pending result; cell contents are not cleared.
// stall
//   while a result waits and out_tready is low, in_tready is low; when the
//   result is taken in the same cycle a new request is accepted.
`default_nettype none
module sorted_insert_array (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [31:0] item_value, [37:32] position, rest zero
  input  wire logic [sia_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] command
  input  wire logic [1:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] read_value, [38:32] entry_count, rest zero
  output logic      [sia_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic      [1:0]                        out_tuser
);
  import sia_pkg::*;

  // request fields
  logic [VALUE_WIDTH-1:0] item;
  logic [POS_W-1:0]       pos;
  logic                   accept;
  logic                   full;
  logic                   pos_ok;

  // store state
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;

  // result register
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] rd_r;
  logic [VALUE_WIDTH-1:0] rd_nxt;
  logic                   rd_hit;
  status_t                st_r;
  status_t                st_nxt;
  logic [CNT_W-1:0]       cnt_out_r;

  cell_ctl_t              ctl;
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_rd  [CAPACITY];
  logic                   cell_gt  [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_sel;

  assign item   = in_tdata[VALUE_WIDTH-1:0];
  assign pos    = in_tdata[VALUE_WIDTH +: POS_W];
  assign accept = in_tvalid && in_tready;
  assign full   = (count_r == CNT_W'(CAPACITY));
  // compare in a width that holds both the position field and the count
  assign pos_ok = (CNT_W + POS_W)'(pos) < (CNT_W + POS_W)'(count_r);

  // output register frees up whenever the receiver takes the result
  assign in_tready = !out_valid_r || out_tready;

  always_comb begin
    ctl.ins_en = 1'b0;
    ctl.rem_en = 1'b0;
    ctl.item   = item;
    // only used when pos_ok, and then it fits the count width
    ctl.pos    = CNT_W'(pos);
    ctl.count  = count_r;
    rd_hit     = 1'b0;
    st_nxt     = ST_OK;
    count_nxt  = count_r;
    case (cmd_t'(in_tuser))
      CMD_INSERT: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          ctl.ins_en = accept;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_ok) begin
          rd_hit = 1'b1;
        end else begin
          st_nxt = ST_BADPOS;
        end
      end
      CMD_REMOVE: begin
        if (pos_ok) begin
          ctl.rem_en = accept;
          count_nxt  = count_r - CNT_W'(1);
        end else begin
          st_nxt = ST_BADPOS;
        end
      end
      default: begin
        // unused code leaves everything as it is
      end
    endcase
  end

  // read word only for a valid read, zero for every other result
  assign rd_nxt = rd_hit ? rd_sel : '0;

  // row of cells, each talking to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val;
    logic                   left_gt;
    logic [VALUE_WIDTH-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    sia_cell u_cell (
      .clk         (clk),
      .ctl_i       (ctl),
      .idx_i       (CNT_W'(i)),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i]),
      .rd_o        (cell_rd[i])
    );
  end

  // read select: only the addressed cell drives a nonzero word
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r      <= rd_nxt;
      st_r      <= st_nxt;
      cnt_out_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({cnt_out_r, rd_r});
  assign out_tuser  = st_r;

endmodule
`default_nettype wire

### rtl/sia_cell.sv
// one storage cell of the sorted array, shifting with its neighbors
`default_nettype none
module sia_cell (
  input  wire logic                            clk,
  input  wire sia_pkg::cell_ctl_t              ctl_i,
  input  wire logic [sia_pkg::CNT_W-1:0]       idx_i,
  input  wire logic [sia_pkg::VALUE_WIDTH-1:0] left_val_i,
  input  wire logic                            left_gt_i,
  input  wire logic [sia_pkg::VALUE_WIDTH-1:0] right_val_i,
  output logic      [sia_pkg::VALUE_WIDTH-1:0] val_o,
  output logic                                 gt_o,
  output logic      [sia_pkg::VALUE_WIDTH-1:0] rd_o
);
  import sia_pkg::*;

  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] val_nxt;
  logic                   in_use;

  assign in_use = idx_i < ctl_i.count;
  // valid cells greater than the new item form a contiguous upper run
  assign gt_o   = in_use && (val_r > ctl_i.item);
  assign val_o  = val_r;
  assign rd_o   = (idx_i == ctl_i.pos) ? val_r : '0;

  always_comb begin
    val_nxt = val_r;
    if (ctl_i.ins_en) begin
      if (left_gt_i) begin
        val_nxt = left_val_i;
      end else if (gt_o || (idx_i == ctl_i.count)) begin
        val_nxt = ctl_i.item;
      end
    end else if (ctl_i.rem_en) begin
      if (idx_i >= ctl_i.pos) begin
        val_nxt = right_val_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

### rtl/sia_checker.sv
// port-level checker for the sorted insert array, bound to the top level
`default_nettype none
module sia_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [sia_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]                     out_tuser
);
  import sia_pkg::*;

  logic [CNT_W-1:0] out_cnt;
  assign out_cnt = out_tdata[VALUE_WIDTH +: CNT_W];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // every accepted request shows its result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("result missing after request");

  // a dropped insert only happens with the store full
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> out_cnt == CNT_W'(CAPACITY))
    else $error("full status with room left");

  // bad position reads zero and the count never passes the capacity
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_cnt <= CNT_W'(CAPACITY)) &&
                   ((out_tuser != ST_BADPOS) || (out_tdata[VALUE_WIDTH-1:0] == '0)))
    else $error("bad result word");

  // the next count moves by at most one from the previous result
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready ##1 out_tvalid |->
      (out_cnt == $past(out_cnt)) || (out_cnt == $past(out_cnt) + CNT_W'(1)) ||
      (out_cnt == $past(out_cnt) - CNT_W'(1)))
    else $error("count jumped");

endmodule

bind sorted_insert_array sia_checker u_sia_checker (.*);
`default_nettype wire

### tb/tb_sorted_insert_array.sv
// testbench for the sorted insert array: directed and random requests checked against a predictor
`default_nettype none
module tb_sorted_insert_array;
  timeunit 1ns;
  timeprecision 1ps;

  import sia_pkg::*;

  localparam logic [1:0] CMD_SPARE      = 2'd3;   // unused command code, must change nothing
  localparam int         WATCHDOG_LIMIT = 2000;   // cycles without any handshake
  localparam int         DRAIN_CYCLES   = 8;      // result register latency plus margin
  localparam int         MAX_REPORTS    = 60;
  localparam int         RANDOM_ITEMS   = 600;

  typedef struct {
    logic [VALUE_WIDTH-1:0] read_value;
    status_t                status;
    logic [CNT_W-1:0]       entry_count;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = 2'd0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  // predictor state: sorted contents and count as the block should hold them
  logic [VALUE_WIDTH-1:0] held_vals [CAPACITY];
  int                     held_count = 0;

  result_t pending_results [$];
  int      fail_count   = 0;
  int      report_count = 0;
  int      idle_cycles  = 0;
  int      stall_left   = 0;
  bit      steady_flow  = 1'b0;   // no new gaps are started on either side while set

  sorted_insert_array u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // values cluster on extremes and small numbers so duplicates show up
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 15);
      3: return 32'h8000_0000 + $urandom_range(0, 3) - 2;
      default: return $urandom;
    endcase
  endfunction

  // mostly a live position, otherwise anything the field allows
  function automatic logic [POS_W-1:0] pick_position();
    if (held_count > 0 && $urandom_range(0, 9) < 8)
      return POS_W'($urandom_range(0, held_count - 1));
    return POS_W'($urandom_range(0, CAPACITY - 1));
  endfunction

  // updates the predicted store for one request and returns its result
  function automatic result_t apply_command(logic [1:0] cmd, logic [VALUE_WIDTH-1:0] value,
                                            logic [POS_W-1:0] pos);
    result_t r;
    int      slot;
    r.read_value = '0;
    r.status     = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // equal values stay ahead of the newcomer
          slot = 0;
          while (slot < held_count && !(held_vals[slot] > value)) slot++;
          for (int i = held_count; i > slot; i--) held_vals[i] = held_vals[i-1];
          held_vals[slot] = value;
          held_count++;
        end
      end
      CMD_READ: begin
        if (pos < held_count) r.read_value = held_vals[pos];
        else r.status = ST_BADPOS;
      end
      CMD_REMOVE: begin
        if (pos < held_count) begin
          for (int i = pos; i + 1 < held_count; i++) held_vals[i] = held_vals[i+1];
          held_count--;
        end else begin
          r.status = ST_BADPOS;
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(held_count);
    return r;
  endfunction

  // drives one request, waits for the handshake and records the expected result;
  // entered and left right after a rising edge
  task automatic send_request(logic [1:0] cmd, logic [VALUE_WIDTH-1:0] value,
                              logic [POS_W-1:0] pos);
    int                   gap;
    logic [IN_DATA_W-1:0] word;
    gap = steady_flow ? 0 : idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[0 +: VALUE_WIDTH]         = value;
    word[VALUE_WIDTH +: POS_W]     = pos;
    in_tdata  <= word;
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_command(cmd, value, pos));
  endtask

  // empty store: every lookup and remove is out of range, spare code is inert
  task automatic test_empty_store();
    steady_flow = 1'b0;
    send_request(CMD_READ, '0, '0);
    send_request(CMD_REMOVE, '1, '0);
    send_request(CMD_READ, '0, '1);
    send_request(CMD_SPARE, '1, '1);
  endtask

  // ordering with extreme and repeated values, edge positions, spare code with data
  task automatic test_order_and_extremes();
    steady_flow = 1'b1;
    send_request(CMD_INSERT, 32'hFFFF_FFFF, '0);
    send_request(CMD_INSERT, 32'h0000_0000, '1);
    send_request(CMD_INSERT, 32'h8000_0000, '0);
    send_request(CMD_INSERT, 32'h7FFF_FFFF, '0);
    send_request(CMD_INSERT, 32'h8000_0000, '0);
    send_request(CMD_INSERT, 32'h0000_0000, '0);
    for (int p = 0; p < 7; p++) send_request(CMD_READ, '0, POS_W'(p));
    steady_flow = 1'b0;
    send_request(CMD_SPARE, 32'hA5A5_A5A5, 6'd2);
    send_request(CMD_REMOVE, '0, 6'd6);
    send_request(CMD_REMOVE, '0, 6'd5);
    send_request(CMD_REMOVE, '0, 6'd2);
    send_request(CMD_READ, '0, 6'd2);
    send_request(CMD_REMOVE, '0, 6'd0);
    send_request(CMD_READ, '0, 6'd0);
  endtask

  // fill to capacity, push against the full store, then drain to empty
  task automatic test_full_store();
    steady_flow = 1'b1;
    while (held_count < CAPACITY) send_request(CMD_INSERT, pick_value(), pick_position());
    steady_flow = 1'b0;
    repeat (3) send_request(CMD_INSERT, pick_value(), pick_position());
    send_request(CMD_READ, '0, 6'd63);
    send_request(CMD_READ, '0, 6'd0);
    send_request(CMD_REMOVE, '0, 6'd63);
    send_request(CMD_INSERT, '1, '0);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_READ, '0, 6'd63);
    while (held_count > 0) begin
      if ($urandom_range(0, 2) == 0) send_request(CMD_READ, '0, pick_position());
      else send_request(CMD_REMOVE, pick_value(),
                        POS_W'($urandom_range(0, held_count - 1)));
    end
    send_request(CMD_READ, '0, 6'd0);
    send_request(CMD_REMOVE, '0, 6'd0);
  endtask

  // random traffic in segments that lean toward filling or draining the store
  task automatic test_random_traffic();
    int insert_pct;
    int r;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        steady_flow = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0: insert_pct = 20;
          1: insert_pct = 50;
          2: insert_pct = 80;
          default: insert_pct = 95;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r == 0) send_request(CMD_SPARE, pick_value(), pick_position());
      else if (r <= insert_pct) send_request(CMD_INSERT, pick_value(), pick_position());
      else if (r[0]) send_request(CMD_READ, pick_value(), pick_position());
      else send_request(CMD_REMOVE, pick_value(), pick_position());
    end
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 99) < 25) stall_left = idle_gap();
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t          want;
    logic [CNT_W-1:0] got_count;
    if (rst_n && out_tvalid && out_tready) begin
      got_count = out_tdata[VALUE_WIDTH +: CNT_W];
      if (pending_results.size() == 0) begin
        fail_count++;
        if (report_count++ < MAX_REPORTS)
          $display("%0t unexpected result: expected none, actual data %h status %h",
                   $time, out_tdata, out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0 +: VALUE_WIDTH] !== want.read_value) begin
          fail_count++;
          if (report_count++ < MAX_REPORTS)
            $display("%0t read_value mismatch: expected %h actual %h",
                     $time, want.read_value, out_tdata[0 +: VALUE_WIDTH]);
        end
        if (out_tuser !== want.status) begin
          fail_count++;
          if (report_count++ < MAX_REPORTS)
            $display("%0t status mismatch: expected %0d actual %0d",
                     $time, want.status, out_tuser);
        end
        if (got_count !== want.entry_count) begin
          fail_count++;
          if (report_count++ < MAX_REPORTS)
            $display("%0t entry_count mismatch: expected %0d actual %0d",
                     $time, want.entry_count, got_count);
        end
      end
    end
  end

  // ends a hung run: too long without a handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_store();
    test_order_and_extremes();
    test_full_store();
    test_random_traffic();
    in_tvalid  <= 1'b0;
    steady_flow = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
